@@ rtl/hmp_pkg.sv @@
// ----------------------------------------------------------------------------
// hmp_pkg
// shared types and constants of the track event parser
// ----------------------------------------------------------------------------
package hmp_pkg;

  localparam int TICK_BITS_DEF     = 32;
  localparam int META_LEN_BITS_DEF = 28;
  localparam int RESULT_DEPTH      = 8;

  localparam int TICK_OUT_W = 32;
  localparam int PLEN_OUT_W = 28;
  localparam int TDATA_W    = 80;
  localparam int TUSER_W    = 3;

  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] VOICE_MIN      = 8'h80;
  localparam logic [7:0] VOICE_MAX      = 8'hEF;
  localparam logic [7:0] FAMILY_MASK    = 8'hF0;
  localparam logic [7:0] FAM_PROGRAM    = 8'hC0;
  localparam logic [7:0] FAM_PRESSURE   = 8'hD0;
  localparam logic [7:0] META_END_TRACK = 8'h2F;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PAYLOAD,
    KIND_DONE,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BODY_END,
    ERR_BAD_STATUS,
    ERR_META_TRUNC,
    ERR_VOICE_TRUNC
  } err_t;

  typedef struct packed {
    kind_t                   kind;
    logic [TICK_OUT_W-1:0]   tick;
    logic [7:0]              st;
    logic                    meta;
    logic [PLEN_OUT_W-1:0]   plen;
    logic [7:0]              pbyte;
    err_t                    err;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ rtl/hmp_parse_core.sv @@
// ----------------------------------------------------------------------------
// hmp_parse_core
// per-byte parse state and result generation, up to two results per byte
// ----------------------------------------------------------------------------
module hmp_parse_core #(
  parameter int TICK_BITS     = hmp_pkg::TICK_BITS_DEF,
  parameter int META_LEN_BITS = hmp_pkg::META_LEN_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic [31:0]     body_len,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output hmp_pkg::push_t  push
);
  import hmp_pkg::*;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_MTYPE,
    PH_MLEN,
    PH_VDATA,
    PH_MDATA
  } phase_t;

  localparam logic [6:0] SHIFT_LIM = 7'(TICK_BITS);

  phase_t                   phase, phase_next;
  logic [TICK_BITS-1:0]     tick, tick_next;
  logic [5:0]               shift, shift_next;
  logic [31:0]              consumed;
  logic [META_LEN_BITS-1:0] pending, pending_next;
  logic [META_LEN_BITS-1:0] lacc, lacc_next;
  logic [2:0]               vcnt, vcnt_next;
  logic [7:0]               held, held_next;
  logic                     end_seen, end_seen_next;

  logic [31:0]              consumed_inc;
  logic [31:0]              remaining;
  logic                     active;
  logic [META_LEN_BITS-1:0] lacc_new;
  logic [2:0]               vcnt_new;
  logic [META_LEN_BITS-1:0] pending_dec;
  logic [1:0]               voice_len;
  logic                     do_end;
  logic                     end_meta;
  logic [TICK_OUT_W-1:0]    tick_out;

  function automatic result_t mk(kind_t k, logic [7:0] st, logic meta,
                                 logic [PLEN_OUT_W-1:0] plen, logic [7:0] pb,
                                 err_t e, logic [TICK_OUT_W-1:0] t);
    result_t r;
    r.kind  = k;
    r.tick  = t;
    r.st    = st;
    r.meta  = meta;
    r.plen  = plen;
    r.pbyte = pb;
    r.err   = e;
    r.last  = 1'b0;
    return r;
  endfunction

  assign consumed_inc = consumed + 32'd1;
  assign remaining    = body_len - consumed_inc;
  assign active       = in_valid && !end_seen && (consumed < body_len);
  assign lacc_new     = META_LEN_BITS'({lacc, in_byte[6:0]});
  assign vcnt_new     = vcnt + 3'd1;
  assign pending_dec  = (pending != '0) ? pending - META_LEN_BITS'(1) : pending;
  assign voice_len    = (((in_byte & FAMILY_MASK) == FAM_PROGRAM) ||
                         ((in_byte & FAMILY_MASK) == FAM_PRESSURE)) ? 2'd1 : 2'd2;
  assign tick_out     = TICK_OUT_W'(tick_next);

  always_comb begin
    phase_next    = phase;
    tick_next     = tick;
    shift_next    = shift;
    pending_next  = pending;
    lacc_next     = lacc;
    vcnt_next     = vcnt;
    held_next     = held;
    end_seen_next = end_seen;
    do_end        = 1'b0;
    end_meta      = 1'b0;
    push          = '0;

    if (active) begin
      unique case (phase)
        PH_DELTA: begin
          if ({1'b0, shift} < SHIFT_LIM) begin
            tick_next = tick + (TICK_BITS'(in_byte[6:0]) << shift);
          end
          shift_next = (shift > 6'd56) ? 6'd63 : shift + 6'd7;
          if (in_byte[7]) begin
            phase_next = PH_STATUS;
          end
          if (remaining == '0) begin
            push.num      = 2'd1;
            push.first    = mk(KIND_ERROR, '0, 1'b0, '0, '0, ERR_BODY_END, tick_out);
            end_seen_next = 1'b1;
          end
        end
        PH_STATUS: begin
          if (in_byte == STATUS_META) begin
            if (remaining == '0) begin
              push.num      = 2'd1;
              push.first    = mk(KIND_ERROR, '0, 1'b0, '0, '0, ERR_META_TRUNC, tick_out);
              end_seen_next = 1'b1;
            end else begin
              phase_next = PH_MTYPE;
            end
          end else if (in_byte >= VOICE_MIN && in_byte <= VOICE_MAX) begin
            if (remaining < 32'(voice_len)) begin
              push.num      = 2'd1;
              push.first    = mk(KIND_ERROR, '0, 1'b0, '0, '0, ERR_VOICE_TRUNC, tick_out);
              end_seen_next = 1'b1;
            end else begin
              held_next    = in_byte;
              pending_next = META_LEN_BITS'(voice_len);
              phase_next   = PH_VDATA;
              push.num     = 2'd1;
              push.first   = mk(KIND_HEADER, in_byte, 1'b0, PLEN_OUT_W'(voice_len), '0,
                                ERR_NONE, tick_out);
            end
          end else begin
            push.num      = 2'd1;
            push.first    = mk(KIND_ERROR, '0, 1'b0, '0, '0, ERR_BAD_STATUS, tick_out);
            end_seen_next = 1'b1;
          end
        end
        PH_MTYPE: begin
          held_next  = in_byte;
          lacc_next  = '0;
          vcnt_next  = '0;
          phase_next = PH_MLEN;
          if (remaining == '0) begin
            push.num      = 2'd1;
            push.first    = mk(KIND_ERROR, '0, 1'b0, '0, '0, ERR_META_TRUNC, tick_out);
            end_seen_next = 1'b1;
          end
        end
        PH_MLEN: begin
          lacc_next = lacc_new;
          vcnt_next = vcnt_new;
          if (in_byte[7] && vcnt_new < 3'd4) begin
            if (remaining == '0) begin
              push.num      = 2'd1;
              push.first    = mk(KIND_ERROR, '0, 1'b0, '0, '0, ERR_META_TRUNC, tick_out);
              end_seen_next = 1'b1;
            end
          end else if (remaining < 32'(lacc_new)) begin
            push.num      = 2'd1;
            push.first    = mk(KIND_ERROR, '0, 1'b0, '0, '0, ERR_META_TRUNC, tick_out);
            end_seen_next = 1'b1;
          end else begin
            push.num     = 2'd1;
            push.first   = mk(KIND_HEADER, held, 1'b1, PLEN_OUT_W'(lacc_new), '0,
                              ERR_NONE, tick_out);
            pending_next = lacc_new;
            if (lacc_new == '0) begin
              do_end   = 1'b1;
              end_meta = 1'b1;
            end else begin
              phase_next = PH_MDATA;
            end
          end
        end
        PH_VDATA, PH_MDATA: begin
          push.num     = 2'd1;
          push.first   = mk(KIND_PAYLOAD, held, (phase == PH_MDATA), '0, in_byte,
                            ERR_NONE, tick_out);
          pending_next = pending_dec;
          if (pending_dec == '0) begin
            do_end   = 1'b1;
            end_meta = (phase == PH_MDATA);
          end
        end
        default: begin
          phase_next = PH_DELTA;
          shift_next = '0;
        end
      endcase

      if (do_end) begin
        if ((end_meta && held == META_END_TRACK) || remaining == '0) begin
          push.num      = 2'd2;
          push.second   = mk(KIND_DONE, '0, 1'b0, '0, '0, ERR_NONE, tick_out);
          end_seen_next = 1'b1;
        end else begin
          phase_next = PH_DELTA;
          shift_next = '0;
        end
      end

      if (push.num == 2'd2) begin
        push.second.last = 1'b1;
      end else if (push.num == 2'd1) begin
        push.first.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase    <= PH_DELTA;
      tick     <= '0;
      shift    <= '0;
      consumed <= '0;
      pending  <= '0;
      lacc     <= '0;
      vcnt     <= '0;
      held     <= '0;
      end_seen <= 1'b0;
    end else if (active) begin
      phase    <= phase_next;
      tick     <= tick_next;
      shift    <= shift_next;
      consumed <= consumed_inc;
      pending  <= pending_next;
      lacc     <= lacc_next;
      vcnt     <= vcnt_next;
      held     <= held_next;
      end_seen <= end_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_second_is_done: assert property (@(posedge clk) disable iff (rst)
    (push.num == 2'd2) |-> (push.second.kind == KIND_DONE && !push.first.last &&
                            push.second.last))
    else $error("second result of a byte is not track done");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    end_seen |-> (push.num == 2'd0))
    else $error("result after track end");

  a_data_phase_pending: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_VDATA || phase == PH_MDATA) && !end_seen) |-> (pending != '0))
    else $error("data phase with no pending payload");
`endif

endmodule

@@ rtl/hmp_result_fifo.sv @@
// ----------------------------------------------------------------------------
// hmp_result_fifo
// result queue, takes up to two results per cycle, gives one per transfer
// ----------------------------------------------------------------------------
module hmp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  hmp_pkg::push_t    push,
  input  logic              pop,
  output logic              out_valid,
  output hmp_pkg::result_t  out_res,
  output logic              room
);
  import hmp_pkg::*;

  localparam int PW = $clog2(RESULT_DEPTH);
  localparam int CW = $clog2(RESULT_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(RESULT_DEPTH - 4);

  result_t          mem [RESULT_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_pop;

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign room      = (count <= ROOM_MAX);
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.num);
      rd_ptr <= rd_ptr + PW'(do_pop);
      count  <= count + CW'(push.num) - CW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + (CW+1)'(push.num)) <= (CW+1)'(RESULT_DEPTH))
    else $error("result queue overflow");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push.num != 2'd3)
    else $error("more than two results in one cycle");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(1) && pop && push.num == 2'd0) |=> !out_valid)
    else $error("queue not empty after last transfer");
`endif

endmodule

@@ rtl/hmp_track_event_parser_top.sv @@
// ----------------------------------------------------------------------------
// hmp_track_event_parser_top
// track body byte parser: event headers, payload bytes, track done, errors
//
//  port group  dir  contents
//  s_t*        in   body bytes, one per transfer
//  m_t*        out  results, one per transfer, tlast on last result of a byte
//  apb         in   track_body_length at address 0, write restarts the parse
//
//  one byte per cycle sustained while s_tready is high; a byte is registered in
//  the input register and its results enter the result queue at the next edge
//  a byte yields up to two results, the queue drains one result per cycle while m_tready is high
//  s_tready drops while the queue has fewer than four free entries
//  rst is synchronous and clears all parse state; no clearing pass
// ----------------------------------------------------------------------------
module hmp_track_event_parser_top #(
  parameter int TICK_BITS     = hmp_pkg::TICK_BITS_DEF,
  parameter int META_LEN_BITS = hmp_pkg::META_LEN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // body_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // event_tick, status_or_type, payload_length, payload_byte, error_code, pad
  output logic [hmp_pkg::TDATA_W-1:0]  m_tdata,
  output logic [hmp_pkg::TUSER_W-1:0]  m_tuser,  // result_kind, is_meta
  output logic                         m_tlast   // last_of_run
);
  import hmp_pkg::*;

  localparam logic REG_BODY_LEN = 1'b0;

  logic [31:0] body_len;
  logic        cfg_write;
  logic        in_valid;
  logic [7:0]  in_byte;
  push_t       push;
  result_t     out_res;
  logic        room;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BODY_LEN);
  assign prdata    = (paddr[2] == REG_BODY_LEN) ? body_len : '0;
  assign s_tready  = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_len <= '0;
    end else if (cfg_write) begin
      body_len <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  hmp_parse_core #(
    .TICK_BITS     (TICK_BITS),
    .META_LEN_BITS (META_LEN_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_write),
    .body_len (body_len),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .push     (push)
  );

  hmp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .room      (room)
  );

  assign m_tdata = {1'b0, out_res.err, out_res.pbyte, out_res.plen, out_res.st,
                    out_res.tick};
  assign m_tuser = {out_res.meta, out_res.kind};
  assign m_tlast = out_res.last;

endmodule
